// File: rtl/core/csmva_pkg.sv
// Shared types and constants for the COO sparse matrix-vector accumulate block.
// Holds the request mode codes, the field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package csmva_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned ACC_W  = 48;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_ACC   = 2'd2,
    MODE_READ  = 2'd3
  } csmva_mode_e;

  typedef struct packed {
    logic capture;
    logic vec_we;
    logic acc_clr;
    logic prod_en;
    logic acc_wb;
    logic out_load;
  } csmva_cmd_t;

  typedef struct packed {
    csmva_mode_e mode;
    logic        row_ok;
    logic        col_ok;
    logic        out_free;
  } csmva_status_t;

endpackage

`default_nettype wire

// File: rtl/core/csmva_req_if.sv
// Request channel: valid/ready handshake with mode, indices and Q1.15 values.
// Depends on csmva_pkg for the field widths.
`default_nettype none

interface csmva_req_if import csmva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] matrix_value;
  logic signed [VAL_W-1:0] vector_value;

  modport source (output valid, mode, row_index, col_index, matrix_value, vector_value,
                  input ready);
  modport sink (input valid, mode, row_index, col_index, matrix_value, vector_value,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/csmva_rsp_if.sv
// Response channel: valid/ready handshake carrying one row readback.
// Depends on csmva_pkg for the field widths.
`default_nettype none

interface csmva_rsp_if import csmva_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        read_row;
  logic signed [ACC_W-1:0] row_sum;
  logic                    saturated;

  modport source (output valid, read_row, row_sum, saturated, input ready);
  modport sink (input valid, read_row, row_sum, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/core/coo_sparse_matvec_accumulate.sv
// COO sparse matrix-vector accumulate. Each request carries a mode: load one vector
// element, clear one row accumulator, accumulate one nonzero (row, col, value) as
// value * x[col] into the 48-bit saturating row accumulator (30 fraction bits,
// sticky saturation flag), or read one row back on the response channel. Requests
// are handled one at a time by a sequencer; load and clear each pass through their
// own write state, accumulate steps through RAM read, multiply and add-and-write
// back, and a read waits until the response register is free. The vector and
// accumulator RAMs are not cleared at reset: load a column before using it and
// clear a row before accumulating into or reading it.
`default_nettype none

module coo_sparse_matvec_accumulate import csmva_pkg::*; #(
  parameter int unsigned ACC_DEPTH = 1024,
  parameter int unsigned VEC_DEPTH = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  csmva_req_if.sink   req_i,
  csmva_rsp_if.source rsp_o
);

  csmva_cmd_t    cmd;
  csmva_status_t status;
  logic          req_ready;

  assign req_i.ready = req_ready;

  csmva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (csmva_mode_e'(req_i.mode)),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  csmva_datapath #(
    .ACC_DEPTH (ACC_DEPTH),
    .VEC_DEPTH (VEC_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (req_i.mode),
    .row_index_i    (req_i.row_index),
    .col_index_i    (req_i.col_index),
    .matrix_value_i (req_i.matrix_value),
    .vector_value_i (req_i.vector_value),
    .cmd_i          (cmd),
    .status_o       (status),
    .rsp_o          (rsp_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/csmva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csmva_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/csmva_ctrl.sv
// Controller: one-hot sequencer that steps each request through its phases.
// Depends on csmva_pkg; drives csmva_datapath through command/status structs.
`default_nettype none

module csmva_ctrl import csmva_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  csmva_mode_e        req_mode_i,
  output logic               req_ready_o,
  input  csmva_status_t      status_i,
  output csmva_cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_CLEAR = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_WB    = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (req_mode_i)
            MODE_LOAD:  state_d = S_LOAD;
            MODE_CLEAR: state_d = S_CLEAR;
            MODE_ACC:   state_d = S_FETCH;
            MODE_READ:  state_d = S_FETCH;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.vec_we = status_i.col_ok;
        state_d      = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.acc_clr = status_i.row_ok;
        state_d       = S_IDLE;
      end
      S_FETCH: begin
        if (status_i.mode == MODE_READ) begin
          state_d = S_RESP;
        end else if (status_i.row_ok && status_i.col_ok) begin
          state_d = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.prod_en = 1'b1;
        state_d       = S_WB;
      end
      S_WB: begin
        cmd_o.acc_wb = 1'b1;
        state_d      = S_IDLE;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/csmva_datapath.sv
// Datapath: request capture, vector and accumulator RAMs, multiplier,
// saturating 48-bit accumulate and the response register.
// Depends on csmva_pkg, csmva_ram and csmva_rsp_if; commanded by csmva_ctrl.
`default_nettype none

module csmva_datapath import csmva_pkg::*; #(
  parameter int unsigned ACC_DEPTH = 1024,
  parameter int unsigned VEC_DEPTH = 1024,
  localparam int unsigned RAW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1,
  localparam int unsigned CAW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [1:0]              mode_i,
  input  wire logic [IDX_W-1:0]        row_index_i,
  input  wire logic [IDX_W-1:0]        col_index_i,
  input  wire logic signed [VAL_W-1:0] matrix_value_i,
  input  wire logic signed [VAL_W-1:0] vector_value_i,
  input  csmva_cmd_t                   cmd_i,
  output csmva_status_t                status_o,
  csmva_rsp_if.source                  rsp_o
);

  logic                    row_ok_w, col_ok_w;
  csmva_mode_e             mode_q;
  logic [IDX_W-1:0]        row_q, col_q;
  logic signed [VAL_W-1:0] mval_q, vval_q;
  logic                    row_ok_q, col_ok_q;

  logic signed [VAL_W-1:0] vec_rdata;
  logic [ACC_W:0]          acc_rdata, acc_wdata;
  logic                    acc_we;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W:0]    sum_w;
  logic                     ovf_w;
  logic signed [ACC_W-1:0]  sum_sat_w;

  logic                    rsp_valid_q;
  logic [IDX_W-1:0]        rsp_row_q;
  logic signed [ACC_W-1:0] rsp_sum_q;
  logic                    rsp_sat_q;

  assign row_ok_w = 32'(row_index_i) < 32'(ACC_DEPTH);
  assign col_ok_w = 32'(col_index_i) < 32'(VEC_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= csmva_mode_e'(mode_i);
      row_q    <= row_index_i;
      col_q    <= col_index_i;
      mval_q   <= matrix_value_i;
      vval_q   <= vector_value_i;
      row_ok_q <= row_ok_w;
      col_ok_q <= col_ok_w;
    end
  end

  csmva_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.vec_we),
    .waddr_i (CAW'(col_q)),
    .wdata_i (vval_q),
    .raddr_i (CAW'(col_q)),
    .rdata_o (vec_rdata)
  );

  // Accumulator entry: sticky saturation flag above the 48-bit sum.
  assign acc_we    = cmd_i.acc_clr | cmd_i.acc_wb;
  assign acc_wdata = cmd_i.acc_wb ? {acc_rdata[ACC_W] | ovf_w, sum_sat_w} : '0;

  csmva_ram #(
    .WIDTH (ACC_W + 1),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (RAW'(row_q)),
    .wdata_i (acc_wdata),
    .raddr_i (RAW'(row_q)),
    .rdata_o (acc_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q <= mval_q * vec_rdata;
    end
  end

  assign sum_w = $signed({acc_rdata[ACC_W-1], acc_rdata[ACC_W-1:0]})
               + (ACC_W + 1)'(prod_q);
  assign ovf_w = sum_w[ACC_W] ^ sum_w[ACC_W-1];

  always_comb begin
    priority if (!ovf_w) begin
      sum_sat_w = sum_w[ACC_W-1:0];
    end else if (sum_w[ACC_W]) begin
      sum_sat_w = ACC_MIN;
    end else begin
      sum_sat_w = ACC_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_row_q <= row_q;
      rsp_sum_q <= row_ok_q ? acc_rdata[ACC_W-1:0] : '0;
      rsp_sat_q <= row_ok_q & acc_rdata[ACC_W];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_row  = rsp_row_q;
  assign rsp_o.row_sum   = rsp_sum_q;
  assign rsp_o.saturated = rsp_sat_q;

  assign status_o.mode     = mode_q;
  assign status_o.row_ok   = row_ok_q;
  assign status_o.col_ok   = col_ok_q;
  assign status_o.out_free = !rsp_valid_q || rsp_o.ready;

  a_acc_wb_when_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture && mode_i == MODE_ACC)
      |-> ##3 (cmd_i.acc_wb == $past(row_ok_w && col_ok_w, 3)))
    else $error("accumulate writeback does not match captured index range");

  a_no_response_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!rsp_valid_q || rsp_o.ready))
    else $error("response register loaded while a response is pending");

  a_single_ram_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.vec_we && acc_we) && !(cmd_i.acc_clr && cmd_i.acc_wb))
    else $error("conflicting RAM writes in one cycle");

endmodule

`default_nettype wire

// File: dv/tb_coo_sparse_matvec_accumulate.sv
// Testbench for coo_sparse_matvec_accumulate: directed, random and backpressure requests
// against a shadow copy of the vector store and the row accumulators.
// Depends on csmva_pkg, csmva_req_if, csmva_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb_coo_sparse_matvec_accumulate;
  import csmva_pkg::*;

  typedef struct {
    csmva_mode_e             mode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] mval;
    logic signed [VAL_W-1:0] vval;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic signed [ACC_W-1:0] sum;
    logic                    sat;
  } readback_t;

  localparam int  NUM_IDX = 1 << IDX_W;
  localparam longint SUM_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) <<< (ACC_W - 1));

  logic clk_i = 1'b0;
  logic rst_ni;

  csmva_req_if req_if ();
  csmva_rsp_if rsp_if ();

  coo_sparse_matvec_accumulate dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [VAL_W-1:0] shadow_vec [NUM_IDX];
  logic signed [ACC_W-1:0] shadow_acc [NUM_IDX];
  logic                    shadow_sat [NUM_IDX];
  bit                      col_loaded [NUM_IDX];
  bit                      row_cleared [NUM_IDX];
  logic [IDX_W-1:0]        loaded_cols [$];
  logic [IDX_W-1:0]        cleared_rows [$];
  readback_t               readback_q [$];

  int mismatches = 0;
  bit idle_on = 1'b1;
  int rsp_hold_cycles = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < 40) begin
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic apply_to_shadow(request_t r);
    longint prod;
    longint sum;
    case (r.mode)
      MODE_LOAD: begin
        shadow_vec[r.col] = r.vval;
        if (!col_loaded[r.col]) begin
          col_loaded[r.col] = 1'b1;
          loaded_cols.push_back(r.col);
        end
      end
      MODE_CLEAR: begin
        shadow_acc[r.row] = '0;
        shadow_sat[r.row] = 1'b0;
        if (!row_cleared[r.row]) begin
          row_cleared[r.row] = 1'b1;
          cleared_rows.push_back(r.row);
        end
      end
      MODE_ACC: begin
        prod = longint'(r.mval) * longint'(shadow_vec[r.col]);
        sum = longint'(shadow_acc[r.row]) + prod;
        if (sum > SUM_HI) begin
          sum = SUM_HI;
          shadow_sat[r.row] = 1'b1;
        end else if (sum < SUM_LO) begin
          sum = SUM_LO;
          shadow_sat[r.row] = 1'b1;
        end
        shadow_acc[r.row] = sum[ACC_W-1:0];
      end
      default: begin
        readback_q.push_back('{row: r.row, sum: shadow_acc[r.row], sat: shadow_sat[r.row]});
      end
    endcase
  endtask

  function automatic request_t make_req(csmva_mode_e mode, int row, int col, int mval, int vval);
    request_t r;
    r.mode = mode;
    r.row  = row[IDX_W-1:0];
    r.col  = col[IDX_W-1:0];
    r.mval = mval[VAL_W-1:0];
    r.vval = vval[VAL_W-1:0];
    return r;
  endfunction

  function automatic int rand_q15();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return -32768;
    if (pick < 8) return 32767;
    if (pick < 10) return 0;
    return $signed($urandom_range(65535) - 32768);
  endfunction

  task automatic issue_request(request_t r);
    int gap;
    if (idle_on && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.mode         <= r.mode;
    req_if.row_index    <= r.row;
    req_if.col_index    <= r.col;
    req_if.matrix_value <= r.mval;
    req_if.vector_value <= r.vval;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    apply_to_shadow(r);
  endtask

  // well-formed random request: accumulates and reads use only loaded columns and cleared rows
  task automatic issue_random_request(int w_load, int w_clear, int w_acc);
    int pick;
    int row;
    int col;
    pick = $urandom_range(99);
    row = cleared_rows[$urandom_range(cleared_rows.size() - 1)];
    col = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    if (pick < w_load) begin
      if ($urandom_range(1)) col = $urandom_range(NUM_IDX - 1);
      issue_request(make_req(MODE_LOAD, $urandom_range(NUM_IDX - 1), col, rand_q15(),
                             rand_q15()));
    end else if (pick < w_load + w_clear) begin
      if ($urandom_range(1)) row = $urandom_range(NUM_IDX - 1);
      issue_request(make_req(MODE_CLEAR, row, $urandom_range(NUM_IDX - 1), rand_q15(),
                             rand_q15()));
    end else if (pick < w_load + w_clear + w_acc) begin
      issue_request(make_req(MODE_ACC, row, col, rand_q15(), rand_q15()));
    end else begin
      issue_request(make_req(MODE_READ, row, $urandom_range(NUM_IDX - 1), rand_q15(),
                             rand_q15()));
    end
  endtask

  task automatic test_directed();
    issue_request(make_req(MODE_LOAD, 1023, 0, 32767, -32768));
    issue_request(make_req(MODE_LOAD, 0, 1023, -32768, 32767));
    issue_request(make_req(MODE_LOAD, 682, 341, 0, -1));
    issue_request(make_req(MODE_LOAD, 341, 682, -1, 0));
    issue_request(make_req(MODE_CLEAR, 0, 1023, -1, -32768));
    issue_request(make_req(MODE_CLEAR, 1023, 0, 32767, 32767));
    issue_request(make_req(MODE_READ, 0, 682, 12345, -12345));
    issue_request(make_req(MODE_ACC, 0, 0, -32768, 7));
    issue_request(make_req(MODE_ACC, 0, 0, -32768, -7));
    issue_request(make_req(MODE_ACC, 0, 1023, 32767, 0));
    issue_request(make_req(MODE_ACC, 1023, 1023, -32768, 1));
    issue_request(make_req(MODE_ACC, 1023, 0, 32767, -1));
    issue_request(make_req(MODE_ACC, 1023, 341, -32768, 32767));
    issue_request(make_req(MODE_ACC, 1023, 682, 32767, -32768));
    issue_request(make_req(MODE_READ, 0, 0, 0, 0));
    issue_request(make_req(MODE_READ, 1023, 1023, -32768, 32767));
    issue_request(make_req(MODE_LOAD, 0, 0, 0, 32767));
    issue_request(make_req(MODE_ACC, 0, 0, 32767, -32768));
    issue_request(make_req(MODE_READ, 0, 341, -1, -1));
    issue_request(make_req(MODE_CLEAR, 0, 0, 0, 0));
    issue_request(make_req(MODE_READ, 0, 1023, 32767, -32768));
  endtask

  task automatic test_random_mix(int count);
    repeat (count) issue_random_request(12, 8, 55);
  endtask

  // full y = A*x pass over a small block of rows and columns
  task automatic test_matvec_pass(int n_rows, int n_cols, int nnz);
    int row_base;
    int col_base;
    row_base = $urandom_range(NUM_IDX - n_rows);
    col_base = $urandom_range(NUM_IDX - n_cols);
    for (int c = 0; c < n_cols; c++) begin
      issue_request(make_req(MODE_LOAD, $urandom_range(NUM_IDX - 1), col_base + c,
                             rand_q15(), rand_q15()));
    end
    for (int r = 0; r < n_rows; r++) begin
      issue_request(make_req(MODE_CLEAR, row_base + r, $urandom_range(NUM_IDX - 1),
                             rand_q15(), rand_q15()));
    end
    repeat (nnz) begin
      issue_request(make_req(MODE_ACC, row_base + $urandom_range(n_rows - 1),
                             col_base + $urandom_range(n_cols - 1), rand_q15(), rand_q15()));
    end
    for (int r = 0; r < n_rows; r++) begin
      issue_request(make_req(MODE_READ, row_base + r, $urandom_range(NUM_IDX - 1),
                             rand_q15(), rand_q15()));
    end
  endtask

  task automatic test_no_idle(int count);
    idle_on = 1'b0;
    repeat (count) issue_random_request(10, 5, 45);
    idle_on = 1'b1;
  endtask

  // hold the response side off while reads keep coming, so the input stalls
  task automatic test_output_backpressure();
    rsp_hold_cycles = 400;
    repeat (60) issue_random_request(0, 0, 30);
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (idle_on) begin
        rsp_if.ready <= ($urandom_range(99) >= 7);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    readback_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (readback_q.size() == 0) begin
        report_mismatch("unexpected readback, row", longint'(rsp_if.read_row), 0);
      end else begin
        want = readback_q.pop_front();
        if (rsp_if.read_row !== want.row) begin
          report_mismatch("read_row", longint'(rsp_if.read_row), longint'(want.row));
        end
        if (rsp_if.row_sum !== want.sum) begin
          report_mismatch($sformatf("row_sum of row %0d", want.row),
                          longint'(rsp_if.row_sum), longint'(want.sum));
        end
        if (rsp_if.saturated !== want.sat) begin
          report_mismatch($sformatf("saturated of row %0d", want.row),
                          longint'(rsp_if.saturated), longint'(want.sat));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("coo_sparse_matvec_accumulate: mismatch");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_LOAD;
    req_if.row_index    = '0;
    req_if.col_index    = '0;
    req_if.matrix_value = '0;
    req_if.vector_value = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_mix(700);
    test_matvec_pass(8, 16, 64);
    test_no_idle(400);
    test_output_backpressure();
    test_matvec_pass(4, 8, 24);
    test_random_mix(400);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (readback_q.size() != 0) begin
      report_mismatch("readbacks never returned", 0, longint'(readback_q.size()));
    end
    if (mismatches == 0) begin
      $display("coo_sparse_matvec_accumulate: match");
    end else begin
      $display("coo_sparse_matvec_accumulate: mismatch");
    end
    $finish;
  end

endmodule
